### sv/arqsw_pkg.sv
// Shared constants, codes and beat types of the ARQ sender window.
package arqsw_pkg;

    localparam int DEPTH = 31;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_NACK = 2'd2;
    localparam logic [1:0] KIND_TICK = 2'd3;

    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_SEND    = 2'd1;
    localparam logic [1:0] ACT_RESEND  = 2'd2;
    localparam logic [1:0] ACT_REFUSED = 2'd3;

    localparam logic [3:0] DUP_HOLDOFF = 4'hB;   // -5
    localparam logic [3:0] DUP_FAST    = 4'd3;
    localparam logic [7:0] CREDIT_RST  = 8'd1;
    localparam logic [7:0] TIMEOUT_RST = 8'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  seqnum;
        logic [4:0]  window;
        logic [31:0] now;
        logic        finishing;
    } t_in_item;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] out_seqnum;
        logic [4:0] in_flight;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan_rd;
        logic scan_chk;
        logic scan_end;
    } t_ctl_cmd;

    typedef struct packed {
        logic is_tick;
        logic scan_done;
    } t_ctl_sts;

endpackage

### sv/arq_sender_window_top.sv
// Top level of the ARQ sender window: sequencer plus datapath.
//
//  channel   direction  signals                          beat taken when
//  command   in         start, busy, i_cmd               start && !busy
//  result    out        o_res_valid, o_res               o_res_valid (one cycle)
//  config    in         i_cfg_valid, o_cfg_ready, data   i_cfg_valid && o_cfg_ready
//
// Send, ack and nack are loaded, run in the exec state and give a registered result beat.
// A tick scans the held entries with a read and a check state each, then ends; the single-port
// send-time memory is read one entry per step.
// Reset is synchronous and active low; the receiver cannot stall results.
module arq_sender_window_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  arqsw_pkg::t_in_item  i_cmd,
    output logic                 o_res_valid,
    output arqsw_pkg::t_out_item o_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_data
);
    import arqsw_pkg::*;

    t_ctl_cmd ctl;
    t_ctl_sts sts;

    arqsw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (ctl),
        .busy    (busy)
    );

    arqsw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    assign o_cfg_ready = 1'b1;

endmodule

### sv/arqsw_ctrl.sv
// Sequencer that steps the datapath through single-step commands and tick scans.
module arqsw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  arqsw_pkg::t_ctl_sts i_sts,
    output arqsw_pkg::t_ctl_cmd o_cmd,
    output logic               busy
);
    import arqsw_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SRD  = 3'd2;
    localparam logic [2:0] S_SCHK = 3'd3;
    localparam logic [2:0] S_SEND = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state = i_sts.is_tick ? S_SRD : S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = S_IDLE;
            end
            S_SRD: begin
                if (i_sts.scan_done) begin
                    n_state = S_SEND;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                o_cmd.scan_chk = 1'b1;
                n_state = S_SRD;
            end
            S_SEND: begin
                o_cmd.scan_end = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

### sv/arqsw_dp.sv
// Window state, send-time memory and result register of the ARQ sender.
module arqsw_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  arqsw_pkg::t_in_item i_cmd,
    input  logic                i_cfg_valid,
    input  logic [7:0]          i_cfg_data,
    input  arqsw_pkg::t_ctl_cmd i_ctl,
    output arqsw_pkg::t_ctl_sts o_sts,
    output logic                o_res_valid,
    output arqsw_pkg::t_out_item o_res
);
    import arqsw_pkg::*;

    logic [31:0] mem [DEPTH];

    t_in_item    r_item;
    logic [CW-1:0] r_held, n_held;
    logic [PW-1:0] r_head, n_head;
    logic [7:0]  r_next_seq, n_next_seq;
    logic [7:0]  r_credit, n_credit;
    logic [7:0]  r_sent, n_sent;
    logic [7:0]  r_dup_seq, n_dup_seq;
    logic [3:0]  r_dup_cnt, n_dup_cnt;
    logic [7:0]  r_timeout;
    logic [CW-1:0] r_idx;
    logic [PW-1:0] r_addr;
    logic [31:0] r_rdata;
    logic        r_pend, n_pend;
    logic [7:0]  r_pend_seq, n_pend_seq;
    logic        r_res_valid, n_res_valid;
    t_out_item   r_res, n_res;

    logic [7:0]    head_seq, off8, sent_inc;
    logic [CW-1:0] off, rest;
    logic [PW+1:0] sum_ack, sum_tail;
    logic [PW-1:0] ack_head, tail_addr, addr_inc;
    logic          useful, send_ok, nack_hit, expired, mem_we;
    logic [3:0]    dup_new;
    logic [31:0]   age;

    assign head_seq = r_next_seq - 8'(r_held);
    assign off8     = r_item.seqnum - head_seq;
    assign sent_inc = (r_sent != 8'hFF) ? r_sent + 8'd1 : r_sent;
    assign useful   = (r_held == '0) || (off8 <= 8'(r_held));
    assign off      = (r_held == '0) ? '0 : CW'(off8);
    assign rest     = r_held - off;
    assign nack_hit = off8 < 8'(r_held);
    assign send_ok  = (r_sent < r_credit) && (r_held < CW'(DEPTH));
    assign dup_new  = (r_dup_seq == r_item.seqnum) ? r_dup_cnt + 4'd1 : 4'd1;

    // Circular buffer pointers wrap with one compare and subtract; the scan address wraps to zero.
    assign sum_ack   = (PW+2)'(r_head) + (PW+2)'(off);
    assign ack_head  = (sum_ack >= (PW+2)'(DEPTH)) ? PW'(sum_ack - (PW+2)'(DEPTH))
                                                   : PW'(sum_ack);
    assign sum_tail  = (PW+2)'(r_head) + (PW+2)'(r_held);
    assign tail_addr = (sum_tail >= (PW+2)'(DEPTH)) ? PW'(sum_tail - (PW+2)'(DEPTH))
                                                    : PW'(sum_tail);
    assign addr_inc  = ((PW+1)'(r_addr) + 1'b1 >= (PW+1)'(DEPTH)) ? '0 : r_addr + 1'b1;

    assign age     = r_item.now - r_rdata;
    assign expired = age > {24'd0, r_timeout};
    assign mem_we  = i_ctl.exec && (r_item.kind == KIND_SEND) && send_ok;

    assign o_sts.is_tick   = (i_cmd.kind == KIND_TICK);
    assign o_sts.scan_done = (r_idx == r_held);

    always_comb begin
        n_held      = r_held;
        n_head      = r_head;
        n_next_seq  = r_next_seq;
        n_credit    = r_credit;
        n_sent      = r_sent;
        n_dup_seq   = r_dup_seq;
        n_dup_cnt   = r_dup_cnt;
        n_pend      = r_pend;
        n_pend_seq  = r_pend_seq;
        n_res_valid = 1'b0;
        n_res       = r_res;
        if (i_ctl.load) begin
            n_pend = 1'b0;
        end
        if (i_ctl.exec) begin
            n_res_valid      = 1'b1;
            n_res.action     = ACT_NONE;
            n_res.out_seqnum = 8'd0;
            n_res.last       = 1'b1;
            unique case (r_item.kind)
                KIND_SEND: begin
                    if (send_ok) begin
                        n_held           = r_held + 1'b1;
                        n_next_seq       = r_next_seq + 8'd1;
                        n_sent           = sent_inc;
                        n_res.action     = ACT_SEND;
                        n_res.out_seqnum = r_next_seq;
                    end else begin
                        n_res.action = ACT_REFUSED;
                    end
                end
                KIND_ACK: begin
                    if (useful) begin
                        n_held    = rest;
                        n_head    = ack_head;
                        n_credit  = {3'd0, r_item.window};
                        n_sent    = 8'd0;
                        n_dup_seq = r_item.seqnum;
                        n_dup_cnt = dup_new;
                        // After freeing, the acked entry is held exactly when it is the oldest.
                        if (rest != '0 && !dup_new[3] && dup_new >= DUP_FAST
                                && !r_item.finishing) begin
                            n_dup_cnt        = DUP_HOLDOFF;
                            n_sent           = 8'd1;
                            n_res.action     = ACT_RESEND;
                            n_res.out_seqnum = r_item.seqnum;
                        end
                    end
                end
                KIND_NACK: begin
                    if (nack_hit) begin
                        n_sent           = sent_inc;
                        n_res.action     = ACT_RESEND;
                        n_res.out_seqnum = r_item.seqnum;
                    end
                end
                default: ;
            endcase
            n_res.in_flight = 5'(n_held);
        end
        // A found entry is held back one step so the final one can carry last.
        if (i_ctl.scan_chk && expired) begin
            n_sent     = sent_inc;
            n_pend     = 1'b1;
            n_pend_seq = head_seq + 8'(r_idx);
            if (r_pend) begin
                n_res_valid      = 1'b1;
                n_res.action     = ACT_RESEND;
                n_res.out_seqnum = r_pend_seq;
                n_res.in_flight  = 5'(r_held);
                n_res.last       = 1'b0;
            end
        end
        if (i_ctl.scan_end) begin
            n_res_valid      = 1'b1;
            n_res.action     = r_pend ? ACT_RESEND : ACT_NONE;
            n_res.out_seqnum = r_pend ? r_pend_seq : 8'd0;
            n_res.in_flight  = 5'(r_held);
            n_res.last       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[tail_addr] <= r_item.now;
        end
        if (i_ctl.scan_rd) begin
            r_rdata <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_item <= i_cmd;
        end
        if (i_ctl.load) begin
            r_idx  <= '0;
            r_addr <= r_head;
        end else if (i_ctl.scan_chk) begin
            r_idx  <= r_idx + 1'b1;
            r_addr <= addr_inc;
        end
        r_pend_seq <= n_pend_seq;
        r_res      <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_head      <= '0;
            r_next_seq  <= 8'd0;
            r_credit    <= CREDIT_RST;
            r_sent      <= 8'd0;
            r_dup_seq   <= 8'd0;
            r_dup_cnt   <= 4'd0;
            r_timeout   <= TIMEOUT_RST;
            r_pend      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_held      <= n_held;
            r_head      <= n_head;
            r_next_seq  <= n_next_seq;
            r_credit    <= n_credit;
            r_sent      <= n_sent;
            r_dup_seq   <= n_dup_seq;
            r_dup_cnt   <= n_dup_cnt;
            r_pend      <= n_pend;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
